/* src/crc_fpb_pkg.sv */
`default_nettype none

package crc_fpb_pkg;

    // largest payload that still builds a frame
    localparam int unsigned MaxPayload = 247;

    // most frame bytes that one input word can produce
    localparam int unsigned BurstDepth = 10;
    localparam int unsigned CntW       = $clog2(BurstDepth + 1);

    localparam logic [7:0]  Crc8Seed      = 8'hFF;
    localparam logic [7:0]  Crc8PolyRefl  = 8'h8C;
    localparam logic [15:0] Crc16Seed     = 16'hFFFF;
    localparam logic [15:0] Crc16PolyRefl = 16'h8408;
    localparam logic [7:0]  StartReset    = 8'hA5;

    // what a queued frame byte is, resolved when it leaves the queue
    typedef enum logic [2:0] {
        TAG_BYTE   = 3'd0,   // literal byte, crc-16 only
        TAG_HDR    = 3'd1,   // literal byte, crc-8 and crc-16
        TAG_CRC8   = 3'd2,   // header crc-8
        TAG_CRC_LO = 3'd3,   // frame crc-16 low byte
        TAG_CRC_HI = 3'd4    // frame crc-16 high byte, end of frame
    } tag_t;

    typedef struct packed {
        tag_t       tag;
        logic [7:0] data;
    } entry_t;

    typedef logic [CntW-1:0] cnt_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ Crc8PolyRefl) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ Crc16PolyRefl) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/crc_framed_packet_builder_unit.sv */
// the frame bytes of an accepted word go into the burst queue, then one at a time through the
//   output register to m_; a packet's first word yields 8 to 10 bytes and the next word is
//   taken in the cycle the last of them moves to the output register
// oversize packets (length above 247) are taken word by word and give no bytes
// reset (aresetn low at a clock edge, synchronous): queue and output empty, sequence 0,
//   both crc registers at their seeds, start byte back to 0xA5
`default_nettype none

module crc_framed_packet_builder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_command_id,
    input  wire logic [15:0] s_payload_len,
    input  wire logic [7:0]  s_data_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_frame_end
);

    import crc_fpb_pkg::*;

    // configuration
    logic [7:0] start_byte_reg;

    // packet control state, updated when a word is accepted
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic        dropping_reg, dropping_next;

    // burst queue: the frame bytes of one word, head at index 0
    entry_t burst_reg [BurstDepth];
    entry_t burst_next [BurstDepth];
    cnt_t   cnt_reg, cnt_next;

    // load image built from the incoming word
    entry_t ld_ent [BurstDepth];
    cnt_t   ld_cnt;

    // running checksums, advanced as bytes leave the queue
    logic [7:0]  crc8_reg, crc8_next;
    logic [15:0] crc16_reg, crc16_next;

    // output register
    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_frame_end_reg;

    logic        pop;
    logic        accept;
    logic [7:0]  pop_byte;
    logic        pop_end;
    logic        first_word;
    logic        len_over;
    logic [15:0] len_m1;
    logic [15:0] left_m1;

    // a byte moves from the queue head when the output register is free or being taken
    assign pop = (cnt_reg != '0) && (!m_valid_reg || m_ready);

    // a new word is loaded only when the queue is empty or drains this cycle
    assign s_ready = (cnt_reg == '0) || ((cnt_reg == cnt_t'(1)) && pop);
    assign accept  = s_valid && s_ready;

    assign first_word = (bytes_left_reg == 16'd0);
    assign len_over   = (s_payload_len > 16'(MaxPayload));
    assign len_m1     = s_payload_len - 16'd1;
    assign left_m1    = bytes_left_reg - 16'd1;

    // build the frame bytes of the incoming word and the next packet state
    always_comb begin
        ld_cnt = '0;
        for (int i = 0; i < BurstDepth; i++) begin
            ld_ent[i] = '{tag: TAG_BYTE, data: 8'h00};
        end
        seq_next        = seq_reg;
        bytes_left_next = bytes_left_reg;
        dropping_next   = dropping_reg;

        if (accept) begin
            if (first_word) begin
                if (len_over) begin
                    // swallow the whole packet silently
                    bytes_left_next = len_m1;
                    dropping_next   = (len_m1 != 16'd0);
                end else begin
                    // header: start, length lo/hi, sequence, crc-8, command lo/hi
                    ld_ent[0] = '{tag: TAG_HDR,  data: start_byte_reg};
                    ld_ent[1] = '{tag: TAG_HDR,  data: s_payload_len[7:0]};
                    ld_ent[2] = '{tag: TAG_HDR,  data: s_payload_len[15:8]};
                    ld_ent[3] = '{tag: TAG_HDR,  data: seq_reg};
                    ld_ent[4] = '{tag: TAG_CRC8, data: 8'h00};
                    ld_ent[5] = '{tag: TAG_BYTE, data: s_command_id[7:0]};
                    ld_ent[6] = '{tag: TAG_BYTE, data: s_command_id[15:8]};
                    seq_next      = seq_reg + 8'd1;
                    dropping_next = 1'b0;
                    if (s_payload_len == 16'd0) begin
                        // empty payload: trailer right after the header
                        ld_ent[7]       = '{tag: TAG_CRC_LO, data: 8'h00};
                        ld_ent[8]       = '{tag: TAG_CRC_HI, data: 8'h00};
                        ld_cnt          = cnt_t'(9);
                        bytes_left_next = 16'd0;
                    end else begin
                        ld_ent[7]       = '{tag: TAG_BYTE, data: s_data_byte};
                        bytes_left_next = len_m1;
                        if (len_m1 == 16'd0) begin
                            ld_ent[8] = '{tag: TAG_CRC_LO, data: 8'h00};
                            ld_ent[9] = '{tag: TAG_CRC_HI, data: 8'h00};
                            ld_cnt    = cnt_t'(10);
                        end else begin
                            ld_cnt = cnt_t'(8);
                        end
                    end
                end
            end else if (dropping_reg) begin
                bytes_left_next = left_m1;
                dropping_next   = (left_m1 != 16'd0);
            end else begin
                // payload word, trailer after the last one
                ld_ent[0]       = '{tag: TAG_BYTE, data: s_data_byte};
                bytes_left_next = left_m1;
                if (left_m1 == 16'd0) begin
                    ld_ent[1] = '{tag: TAG_CRC_LO, data: 8'h00};
                    ld_ent[2] = '{tag: TAG_CRC_HI, data: 8'h00};
                    ld_cnt    = cnt_t'(3);
                end else begin
                    ld_cnt = cnt_t'(1);
                end
            end
        end
    end

    // queue shift on pop, reload on accept (only when it empties)
    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < BurstDepth; i++) begin
            burst_next[i] = burst_reg[i];
        end
        if (pop) begin
            for (int i = 0; i < BurstDepth - 1; i++) begin
                burst_next[i] = burst_reg[i + 1];
            end
            cnt_next = cnt_reg - cnt_t'(1);
        end
        if (accept) begin
            for (int i = 0; i < BurstDepth; i++) begin
                burst_next[i] = ld_ent[i];
            end
            cnt_next = ld_cnt;
        end
    end

    // resolve the head byte and advance the checksums
    always_comb begin
        pop_byte   = burst_reg[0].data;
        pop_end    = 1'b0;
        crc8_next  = crc8_reg;
        crc16_next = crc16_reg;
        unique case (burst_reg[0].tag)
            TAG_HDR: begin
                crc8_next = crc8_step(crc8_reg, pop_byte);
            end
            TAG_CRC8: begin
                pop_byte  = crc8_reg;
                crc8_next = Crc8Seed;
            end
            TAG_CRC_LO: begin
                pop_byte = crc16_reg[7:0];
            end
            TAG_CRC_HI: begin
                pop_byte = crc16_reg[15:8];
                pop_end  = 1'b1;
            end
            default: begin
                pop_byte = burst_reg[0].data;
            end
        endcase
        // the low trailer byte leaves the crc alone so the high byte still sees it
        if (burst_reg[0].tag == TAG_CRC_HI) begin
            crc16_next = Crc16Seed;
        end else if (burst_reg[0].tag != TAG_CRC_LO) begin
            crc16_next = crc16_step(crc16_reg, pop_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= StartReset;
        end else if (cfg_wr_en) begin
            start_byte_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= 8'd0;
            bytes_left_reg <= 16'd0;
            dropping_reg   <= 1'b0;
            cnt_reg        <= '0;
            crc8_reg       <= Crc8Seed;
            crc16_reg      <= Crc16Seed;
            m_valid_reg    <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            bytes_left_reg <= bytes_left_next;
            dropping_reg   <= dropping_next;
            cnt_reg        <= cnt_next;
            if (pop) begin
                crc8_reg    <= crc8_next;
                crc16_reg   <= crc16_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < BurstDepth; i++) begin
            burst_reg[i] <= burst_next[i];
        end
        if (pop) begin
            m_out_byte_reg  <= pop_byte;
            m_frame_end_reg <= pop_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_frame_end = m_frame_end_reg;

    // queue never holds more than one word's bytes
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= cnt_t'(BurstDepth))
        else $error("burst queue count out of range");

    // a word is only taken when the queue will be empty
    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (cnt_reg == '0) || ((cnt_reg == cnt_t'(1)) && pop))
        else $error("word accepted into a busy queue");

    // the frame crc restarts after every trailer
    a_crc_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && burst_reg[0].tag == TAG_CRC_HI) |=> (crc16_reg == Crc16Seed))
        else $error("crc-16 not reseeded after frame end");

    // a dropped packet always owes more words
    a_drop_owes: assert property (@(posedge aclk) disable iff (!aresetn)
        dropping_reg |-> (bytes_left_reg != 16'd0))
        else $error("dropping with no words left");

    // dropped words never reach the queue
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && dropping_reg && !first_word) |=> (cnt_reg == '0))
        else $error("dropped word produced bytes");

endmodule

`default_nettype wire

/* sim/crc_fpb_frame_checker.sv */
`default_nettype none

module crc_fpb_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [15:0] s_command_id,
    input  wire logic [15:0] s_payload_len,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_out_byte,
    input  wire logic        m_frame_end,
    output int               fail_count,
    output int               bytes_due,
    output int               frames_checked,
    output int               bytes_checked
);

    import crc_fpb_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    frame_byte_t frame_bytes_due[$];

    logic [7:0]  start_byte_q;
    logic [7:0]  seq_num;
    logic [15:0] words_owed;
    logic [15:0] frame_crc;
    logic        skipping;

    // bit-serial forms, data enters lsb first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ Crc8PolyRefl;
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ Crc16PolyRefl;
        end
        return c;
    endfunction

    task automatic emit(input logic [7:0] b, input logic last);
        frame_bytes_due.push_back('{value: b, last: last});
        if (!last) frame_crc = crc16_next(frame_crc, b);
    endtask

    task automatic close_frame();
        logic [15:0] c;
        c = frame_crc;
        emit(c[7:0], 1'b0);
        emit(c[15:8], 1'b1);
        frame_crc = Crc16Seed;
    endtask

    task automatic predict_frame_bytes(input logic [15:0] cmd, input logic [15:0] len,
                                       input logic [7:0] data);
        logic [7:0] hdr [4];
        logic [7:0] hcrc;
        if (words_owed == 16'd0) begin
            skipping = 1'b0;
            if (len > MaxPayload) begin
                words_owed = len - 16'd1;
                skipping   = (words_owed != 16'd0);
                return;
            end
            hdr     = '{start_byte_q, len[7:0], len[15:8], seq_num};
            seq_num = seq_num + 8'd1;
            hcrc      = Crc8Seed;
            frame_crc = Crc16Seed;
            foreach (hdr[i]) begin
                hcrc = crc8_next(hcrc, hdr[i]);
                emit(hdr[i], 1'b0);
            end
            emit(hcrc, 1'b0);
            emit(cmd[7:0], 1'b0);
            emit(cmd[15:8], 1'b0);
            if (len == 16'd0) begin
                close_frame();
                return;
            end
            emit(data, 1'b0);
            words_owed = len - 16'd1;
            if (words_owed == 16'd0) close_frame();
        end else if (skipping) begin
            words_owed = words_owed - 16'd1;
            if (words_owed == 16'd0) skipping = 1'b0;
        end else begin
            emit(data, 1'b0);
            words_owed = words_owed - 16'd1;
            if (words_owed == 16'd0) close_frame();
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_byte_t want;
        if (!aresetn) begin
            frame_bytes_due.delete();
            start_byte_q = StartReset;
            seq_num      = 8'd0;
            words_owed   = 16'd0;
            frame_crc    = Crc16Seed;
            skipping     = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected frame byte %02h end %0b", m_out_byte, m_frame_end);
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (want.value !== m_out_byte || want.last !== m_frame_end) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("frame byte %0d: expected %02h end %0b, got %02h end %0b",
                                     bytes_checked, want.value, want.last,
                                     m_out_byte, m_frame_end);
                    end else if (want.last) begin
                        frames_checked++;
                    end
                    bytes_checked++;
                end
            end
            if (s_valid && s_ready)
                predict_frame_bytes(s_command_id, s_payload_len, s_data_byte);
            // a new start byte only affects frames begun after this edge
            if (cfg_wr_en) start_byte_q = cfg_wr_data;
        end
        bytes_due = frame_bytes_due.size();
    end

endmodule

`default_nettype wire

/* sim/tb_crc_framed_packet_builder_unit.sv */
`default_nettype none

module tb_crc_framed_packet_builder_unit;
    import crc_fpb_pkg::*;

    localparam int CycleLimit = 1_500_000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [7:0]  cfg_wr_data   = 8'h00;
    logic        s_valid       = 1'b0;
    logic [15:0] s_command_id  = 16'h0000;
    logic [15:0] s_payload_len = 16'h0000;
    logic [7:0]  s_data_byte   = 8'h00;
    logic        m_ready       = 1'b0;

    wire logic       s_ready;
    wire logic       m_valid;
    wire logic [7:0] m_out_byte;
    wire logic       m_frame_end;

    int fail_count;
    int bytes_due;
    int frames_checked;
    int bytes_checked;

    // run bookkeeping for the summary and the phase goals
    int cycle_count     = 0;
    int words_sent      = 0;
    int frame_words     = 0;
    int packets_dropped = 0;
    int start_settings  = 0;
    int stall_left      = 0;
    bit steady_send     = 1'b0;
    bit steady_recv     = 1'b0;

    crc_framed_packet_builder_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command_id  (s_command_id),
        .s_payload_len (s_payload_len),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_end   (m_frame_end)
    );

    // checker sits beside the block and only watches the ports
    crc_fpb_frame_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command_id   (s_command_id),
        .s_payload_len  (s_payload_len),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_frame_end    (m_frame_end),
        .fail_count     (fail_count),
        .bytes_due      (bytes_due),
        .frames_checked (frames_checked),
        .bytes_checked  (bytes_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d frame bytes still due", cycle_count, bytes_due);
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly no gap, some short ones, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else return $urandom_range(5, 30);
    endfunction

    // payload lengths lean short so the header path gets hit often
    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        else if (r < 35) return 16'($urandom_range(1, 3));
        else if (r < 75) return 16'($urandom_range(4, 16));
        else return 16'($urandom_range(17, 48));
    endfunction

    // result side back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            if (!steady_recv && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // one input word; valid stays up after acceptance until the next call decides
    task automatic send_word(input logic [15:0] cmd, input logic [15:0] len,
                             input logic [7:0] data);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_command_id  = cmd;
        s_payload_len = len;
        s_data_byte   = data;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // whole packet, later words carry random junk in the ignored fields
    task automatic send_packet(input logic [15:0] cmd, input logic [15:0] len);
        int words;
        words = (len == 16'd0) ? 1 : int'(len);
        for (int i = 0; i < words; i++) begin
            if (i == 0) send_word(cmd, len, 8'($urandom));
            else send_word(16'($urandom), 16'($urandom), 8'($urandom));
        end
        if (len > MaxPayload) packets_dropped++;
        else frame_words += words;
    endtask

    // stop sending and let every expected byte come out before touching config
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (bytes_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_start(input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        start_settings++;
    endtask

    initial begin
        logic [7:0] codes [4];
        int         phase_goal [4];
        codes      = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        phase_goal = '{30, 70, 110, 150};

        // reset, released on a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part, start byte still at its reset value
        // empty payload, data word ignored
        send_word(16'h0000, 16'd0, 8'hFF);
        send_word(16'hFFFF, 16'd0, 8'h00);
        // single byte payload, ten bytes from one word
        send_word(16'hA55A, 16'd1, 8'h00);
        send_word(16'h5AA5, 16'd1, 8'hFF);
        // command and length must be ignored after the first word
        send_word(16'h1234, 16'd3, 8'h80);
        send_word(16'hFFFF, 16'hFFFF, 8'h7F);
        send_word(16'h0000, 16'h0000, 8'h01);
        // just over the limit at full rate: swallowed, no sequence bump
        steady_send = 1'b1;
        send_packet(16'hBEEF, 16'(MaxPayload + 1));
        steady_send = 1'b0;
        // frame right after a drop must start clean
        send_word(16'h8001, 16'd2, 8'h55);
        send_word(16'h7FFE, 16'h8000, 8'hAA);

        // random phases, each under its own start byte
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            write_start(codes[phase]);
            steady_send = (phase == 2);
            steady_recv = (phase == 3);
            // a run of empty frames, one word each
            if (phase == 1) repeat (20) send_packet(16'($urandom), 16'd0);
            while (frame_words < phase_goal[phase]) send_packet(16'($urandom), pick_len());
        end
        steady_recv = 1'b0;
        steady_send = 1'b0;

        // short frames to close out
        send_packet(16'($urandom), 16'd1);
        send_packet(16'($urandom), 16'd5);

        // drain, then wait for anything stray
        wait_idle();
        repeat (20) @(negedge aclk);

        $display("%0d words in, %0d frames and %0d frame bytes checked, %0d packets dropped",
                 words_sent, frames_checked, bytes_checked, packets_dropped);
        $display("%0d start byte settings besides reset, %0d mismatches",
                 start_settings, fail_count);
        if (fail_count == 0 && bytes_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
